### design/rgbc_pkg.sv
// Package for the RGB 3x3 convolution block: pixel and window types,
// register indexes, reset values and the per-channel kernel sum.
// Used by every module in the design folder.
package rgbc_pkg;

    typedef logic [23:0] t_pix;          // red 7:0, green 15:8, blue 23:16
    typedef logic [8:0][23:0] t_win;     // window entries 0..8, top-left first

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd600;
    localparam logic [10:0] IMAGE_HEIGHT_RESET = 11'd600;
    localparam logic [10:0] IMAGE_SIZE_MIN     = 11'd3;
    localparam logic [10:0] IMAGE_HEIGHT_MAX   = 11'd1024;

    typedef logic [1:0] t_chan;
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    // Line buffer controls from the pipeline control.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic fwd_hit;
    } t_lb_ctl;

    // Kernel -2 -1 0 / -1 3 1 / 0 1 2, kept modulo 256.
    function automatic logic [7:0] chan_sum(input t_win w, input t_chan ch);
        logic [7:0] a [9];
        logic [7:0] s;
        for (int i = 0; i < 9; i++) begin
            a[i] = w[i][int'(ch) * 8 +: 8];
        end
        s = a[4] + a[4] + a[4] + a[5] + a[7] + {a[8][6:0], 1'b0}
            - {a[0][6:0], 1'b0} - a[1] - a[3];
        return s;
    endfunction

endpackage

### design/rgb_convolution_3x3.sv
// Streaming 3x3 RGB convolution over raster-order pixels.
// Two register stages, the input stage and the result register: a result beat is
// loaded into the result register as its pixel beat leaves the input stage.
// Throughput: one pixel per clock unless the output stalls, set by the single
// read and write port of each line buffer and the window and sum stage.
// Reset: counters to zero, sizes to 600, window to zero; line buffers are not
// cleared and need no clearing pass.
module rgb_convolution_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_frame_start,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_out_col,
    output logic [9:0]  o_out_row,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = ((WB > 11) ? WB : 11) + 1;
    localparam logic [WCW-1:0] W_MIN = WCW'(3);
    localparam logic [WCW-1:0] W_MAX = WCW'(MAX_WIDTH);

    logic [10:0]    r_width;
    logic [10:0]    r_height;
    logic [CW-1:0]  r_col;
    logic [9:0]     r_row;
    logic           r_s1_valid;
    rgbc_pkg::t_pix r_s1_pix;
    logic [CW-1:0]  r_s1_col;
    logic [9:0]     r_s1_row;
    logic           r_o_valid;
    logic [9:0]     r_o_col;
    logic [9:0]     r_o_row;
    logic [7:0]     r_o_red;
    logic [7:0]     r_o_green;
    logic [7:0]     r_o_blue;

    logic [WCW-1:0] w_eff;
    logic [WCW-1:0] col_inc;
    logic [10:0]    h_eff;
    logic [10:0]    row_inc;
    logic [CW-1:0]  cur_col;
    logic [9:0]     cur_row;
    logic [CW-1:0]  n_col;
    logic [9:0]     n_row;
    logic           out_free;
    logic           s1_move;
    logic           acc_in;
    logic           emit;
    rgbc_pkg::t_lb_ctl lb_ctl;
    rgbc_pkg::t_pix up1;
    rgbc_pkg::t_pix up2;
    logic [7:0]     sum_red;
    logic [7:0]     sum_green;
    logic [7:0]     sum_blue;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbc_pkg::IMAGE_WIDTH_RESET;
            r_height <= rgbc_pkg::IMAGE_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgbc_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                rgbc_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes are saturated to the supported range when used.
    always_comb begin
        if (WCW'(r_width) < W_MIN) begin
            w_eff = W_MIN;
        end else if (WCW'(r_width) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = WCW'(r_width);
        end
        if (r_height < rgbc_pkg::IMAGE_SIZE_MIN) begin
            h_eff = rgbc_pkg::IMAGE_SIZE_MIN;
        end else if (r_height > rgbc_pkg::IMAGE_HEIGHT_MAX) begin
            h_eff = rgbc_pkg::IMAGE_HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
    end

    // Position of the beat at the input; a frame start forces the origin.
    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;
        col_inc = WCW'(cur_col) + WCW'(1);
        row_inc = {1'b0, cur_row} + 11'd1;
        n_col   = cur_col;
        n_row   = cur_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? 10'd0 : row_inc[9:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    // Handshake: the input stage advances whenever the result register frees.
    assign out_free   = !r_o_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign acc_in     = i_in_valid && !o_in_stall;
    assign emit       = (r_s1_col >= CW'(2)) && (r_s1_row >= 10'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc_in) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_in || s1_move) begin
            r_s1_valid <= acc_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_pix <= {i_blue_in, i_green_in, i_red_in};
            r_s1_col <= cur_col;
            r_s1_row <= cur_row;
        end
    end

    // The beat in the input stage writes its column as it leaves, so a new
    // beat at the same column takes its data from the bypass.
    always_comb begin
        lb_ctl.rd_en   = acc_in;
        lb_ctl.wr_en   = s1_move;
        lb_ctl.fwd_hit = r_s1_valid && (r_s1_col == cur_col);
    end

    rgbc_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lb_ctl),
        .i_rd_col (cur_col),
        .i_wr_col (r_s1_col),
        .i_wr_pix (r_s1_pix),
        .o_up1    (up1),
        .o_up2    (up2)
    );

    rgbc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_move),
        .i_up2   (up2),
        .i_up1   (up1),
        .i_pix   (r_s1_pix),
        .o_red   (sum_red),
        .o_green (sum_green),
        .o_blue  (sum_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s1_move && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && emit) begin
            r_o_col   <= 10'(r_s1_col - CW'(1));
            r_o_row   <= r_s1_row - 10'd1;
            r_o_red   <= sum_red;
            r_o_green <= sum_green;
            r_o_blue  <= sum_blue;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_col   = r_o_col;
    assign o_out_row   = r_o_row;
    assign o_red_out   = r_o_red;
    assign o_green_out = r_o_green;
    assign o_blue_out  = r_o_blue;

`ifndef SYNTHESIS
    // Only interior pixels are ever reported.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_col != 10'd0) && (o_out_row != 10'd0))
        else $error("result beat outside the interior");

    // Two beats back to back share a column only across a frame start.
    a_fwd_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && lb_ctl.fwd_hit) |-> i_frame_start)
        else $error("line buffer bypass without a frame start");

    // An accepted beat always lands in the input stage.
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_s1_valid)
        else $error("accepted beat lost before the window stage");

    // A result is produced only from a beat that left the input stage.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_o_valid && !s1_move) |=> !r_o_valid)
        else $error("result beat without a source beat");
`endif

endmodule

### design/rgbc_line_buf.sv
// Two line buffers (one and two rows back) with registered reads and a
// bypass for a read of the column that the previous beat writes this cycle.
// Depends on rgbc_pkg.
module rgbc_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rgbc_pkg::t_lb_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_col,
    input  logic [AW-1:0]    i_wr_col,
    input  rgbc_pkg::t_pix   i_wr_pix,
    output rgbc_pkg::t_pix   o_up1,
    output rgbc_pkg::t_pix   o_up2
);

    rgbc_pkg::t_pix r_mem_one [DEPTH];
    rgbc_pkg::t_pix r_mem_two [DEPTH];
    rgbc_pkg::t_pix r_rd_one;
    rgbc_pkg::t_pix r_rd_two;
    rgbc_pkg::t_pix r_fwd_one;
    rgbc_pkg::t_pix r_fwd_two;
    logic           r_fwd;

    assign o_up1 = r_fwd ? r_fwd_one : r_rd_one;
    assign o_up2 = r_fwd ? r_fwd_two : r_rd_two;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_one[i_wr_col] <= i_wr_pix;
        end
        if (i_ctl.rd_en) begin
            r_rd_one <= r_mem_one[i_rd_col];
        end
    end

    // The row two back takes what the row one back held for this column.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_two[i_wr_col] <= o_up1;
        end
        if (i_ctl.rd_en) begin
            r_rd_two <= r_mem_two[i_rd_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_fwd_one <= i_wr_pix;
            r_fwd_two <= o_up1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_ctl.rd_en) begin
            r_fwd <= i_ctl.fwd_hit;
        end
    end

endmodule

### design/rgbc_window.sv
// 3x3 window of pixel registers and the three channel sums of the window
// after the next shift. Depends on rgbc_pkg.
module rgbc_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  rgbc_pkg::t_pix i_up2,
    input  rgbc_pkg::t_pix i_up1,
    input  rgbc_pkg::t_pix i_pix,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue
);

    rgbc_pkg::t_win r_win;
    rgbc_pkg::t_win n_win;

    // Rows shift left by one; the right column takes i_up2, i_up1 and i_pix.
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_up2;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_up1;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    assign o_red   = rgbc_pkg::chan_sum(n_win, rgbc_pkg::CH_RED);
    assign o_green = rgbc_pkg::chan_sum(n_win, rgbc_pkg::CH_GREEN);
    assign o_blue  = rgbc_pkg::chan_sum(n_win, rgbc_pkg::CH_BLUE);

endmodule

### tb/tb_rgb_convolution_3x3.sv
// Self-checking testbench for the streaming 3x3 RGB convolution block.
// A clocked driver and monitor exchange pixel and filtered-pixel beats with the block while
// an in-file predictor computes every expected filtered pixel. Uses rgbc_pkg and the DUT.
`timescale 1ns / 1ps

module tb_rgb_convolution_3x3;

    localparam int MAX_W = 1024;
    localparam int SMALL_W_MAX = 12;
    localparam int SUB_ITEMS = 56;
    localparam int STALL_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int KERNEL [9] = '{-2, -1, 0, -1, 3, 1, 0, 1, 2};
    localparam rgbc_pkg::t_cfg_idx CFG_SPARE_A = 2'd2;
    localparam rgbc_pkg::t_cfg_idx CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic       fs;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_beat;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_filtered_px;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        frame_start = 1'b0;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    // Predictor state.
    logic [10:0]    size_w;
    logic [10:0]    size_h;
    rgbc_pkg::t_pix line_one [MAX_W];
    rgbc_pkg::t_pix line_two [MAX_W];
    rgbc_pkg::t_pix win [9];
    int             col_pos;
    int             row_pos;

    t_pixel_beat  pixel_q [$];
    t_filtered_px filtered_q [$];
    t_pixel_beat  next_beat;
    t_filtered_px want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int pixels_taken = 0;
    int results_checked = 0;
    int settings_used = 0;
    int leftover;

    rgb_convolution_3x3 dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_frame_start (frame_start),
        .i_red_in      (red_in),
        .i_green_in    (green_in),
        .i_blue_in     (blue_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_col     (out_col),
        .o_out_row     (out_row),
        .o_red_out     (red_out),
        .o_green_out   (green_out),
        .o_blue_out    (blue_out)
    );

    always #5 clk = ~clk;

    function automatic int clamp_size(input logic [10:0] v, input int hi);
        if (v < rgbc_pkg::IMAGE_SIZE_MIN) return int'(rgbc_pkg::IMAGE_SIZE_MIN);
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Shifts one pixel through the line buffers and window and queues the filtered
    // pixel when a full window centered one row and one column back is present.
    function automatic void predict_pixel(input logic fs, input logic [7:0] r, g, b);
        int             w;
        int             h;
        int             c;
        int             rw;
        int             acc;
        rgbc_pkg::t_pix up1;
        rgbc_pkg::t_pix up2;
        logic [7:0]     sums [3];
        t_filtered_px   res;
        w = clamp_size(size_w, MAX_W);
        h = clamp_size(size_h, int'(rgbc_pkg::IMAGE_HEIGHT_MAX));
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        rw = row_pos;
        up1 = line_one[c];
        up2 = line_two[c];
        win[0] = win[1]; win[1] = win[2]; win[2] = up2;
        win[3] = win[4]; win[4] = win[5]; win[5] = up1;
        win[6] = win[7]; win[7] = win[8]; win[8] = {b, g, r};
        line_two[c] = up1;
        line_one[c] = {b, g, r};
        if (c >= 2 && rw >= 2) begin
            for (int ch = 0; ch < 3; ch++) begin
                acc = 0;
                for (int k = 0; k < 9; k++) begin
                    acc += int'(win[k][8 * ch +: 8]) * KERNEL[k];
                end
                sums[ch] = 8'(acc);
            end
            res.col = 10'(c - 1);
            res.row = 10'(rw - 1);
            res.red = sums[0];
            res.green = sums[1];
            res.blue = sums[2];
            filtered_q.push_back(res);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic fs, input logic [7:0] r, g, b);
        t_pixel_beat p;
        p.fs = fs;
        p.red = r;
        p.green = g;
        p.blue = b;
        pixel_q.push_back(p);
    endtask

    // Queues frames of random content. Most are whole frames; some are cut short,
    // and the frame after a cut one always starts with frame_start.
    task automatic queue_frames(input int n_items, input int w, input int h,
                                input bit start_fresh);
        int remaining;
        int span;
        bit broken;
        bit first_fs;
        bit need_start;
        remaining = n_items;
        need_start = start_fresh;
        while (remaining > 0) begin
            span = (w * h > 200) ? 200 : w * h;
            broken = (span < w * h) || ($urandom_range(0, 6) == 0);
            if (broken) span = $urandom_range(1, span - 1);
            if (span > remaining) begin
                span = remaining;
                broken = 1'b1;
            end
            first_fs = need_start || ($urandom_range(0, 1) == 1);
            for (int k = 0; k < span; k++) begin
                push_pixel(k == 0 && first_fs, rand_chan(), rand_chan(), rand_chan());
            end
            need_start = broken;
            remaining -= span;
        end
    endtask

    task automatic write_reg(input rgbc_pkg::t_cfg_idx idx, input logic [10:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rgbc_pkg::CFG_IMAGE_WIDTH: size_w = val;
            rgbc_pkg::CFG_IMAGE_HEIGHT: size_h = val;
            default: ;
        endcase
    endtask

    // Waits until every pixel is taken and every filtered pixel has come back,
    // then covers the pipeline latency for pixels that produce nothing.
    task automatic settle();
        while (pixel_q.size() != 0 || in_valid || filtered_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: holds a beat until it is taken, then offers the next one
    // unless the sender decides to idle this cycle.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_pixel(frame_start, red_in, green_in, blue_in);
                pixels_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_beat = pixel_q.pop_front();
                    in_valid <= 1'b1;
                    frame_start <= next_beat.fs;
                    red_in <= next_beat.red;
                    green_in <= next_beat.green;
                    blue_in <= next_beat.blue;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output stall generator.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_checked++;
                if (filtered_q.size() == 0) begin
                    $error("unexpected filtered pixel: col %0d row %0d", out_col, out_row);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, out_col);
                        mismatches++;
                    end
                    if (out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, out_row);
                        mismatches++;
                    end
                    if (red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, red_out);
                        mismatches++;
                    end
                    if (green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, green_out);
                        mismatches++;
                    end
                    if (blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
                        mismatches++;
                    end
                end
            end
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = STALL_HOLD;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int send_pct_tab [4];
        int recv_pct_tab [4];
        logic [10:0] w_reg;
        logic [10:0] h_reg;
        bit pos_tap;
        bit neg_tap;

        send_pct_tab = '{0, 69, 0, 32};
        recv_pct_tab = '{0, 0, 69, 32};
        size_w = rgbc_pkg::IMAGE_WIDTH_RESET;
        size_h = rgbc_pkg::IMAGE_HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        for (int k = 0; k < 9; k++) win[k] = '0;
        for (int k = 0; k < MAX_W; k++) begin
            line_one[k] = '0;
            line_two[k] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the smallest frame: writes to unused indexes must not
        // disturb the sizes, and sizes below the minimum act as 3.
        write_reg(CFG_SPARE_A, 11'd5);
        write_reg(CFG_SPARE_B, 11'h7FF);
        write_reg(rgbc_pkg::CFG_IMAGE_WIDTH, 11'd0);
        write_reg(rgbc_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        settings_used++;
        // First frame gives red its largest and green its smallest sum, blue all ones; the
        // second one follows without frame_start and relies on the wrap after the last row.
        for (int k = 0; k < 9; k++) begin
            pos_tap = KERNEL[k] > 0;
            neg_tap = KERNEL[k] < 0;
            push_pixel(k == 0, pos_tap ? 8'hFF : 8'h00, neg_tap ? 8'hFF : 8'h00, 8'hFF);
        end
        for (int k = 0; k < 9; k++) begin
            pos_tap = KERNEL[k] > 0;
            neg_tap = KERNEL[k] < 0;
            push_pixel(1'b0, pos_tap ? 8'h00 : 8'hFF, neg_tap ? 8'h00 : 8'hFF,
                       k[0] ? 8'hAA : 8'h55);
        end
        // Back-to-back frame starts, then a restart in the middle of a row.
        push_pixel(1'b1, 8'h01, 8'h80, 8'h7F);
        push_pixel(1'b1, 8'hFE, 8'h40, 8'h02);
        push_pixel(1'b0, 8'h10, 8'h20, 8'h04);
        settle();

        // Widest row, reached by clamping the largest register value, then the start
        // of the next row. This leaves both line buffers written over every column
        // that the small frames below use.
        write_reg(rgbc_pkg::CFG_IMAGE_WIDTH, 11'h7FF);
        write_reg(rgbc_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        settings_used++;
        for (int k = 0; k < MAX_W + SMALL_W_MAX; k++) begin
            push_pixel(k == 0, rand_chan(), rand_chan(), rand_chan());
        end
        settle();

        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = send_pct_tab[mode];
            recv_stall_pct = recv_pct_tab[mode];
            for (int sub = 0; sub < 4; sub++) begin
                case ($urandom_range(0, 5))
                    0: w_reg = 11'($urandom_range(0, 2));
                    default: w_reg = 11'($urandom_range(3, SMALL_W_MAX));
                endcase
                case ($urandom_range(0, 6))
                    0: h_reg = 11'($urandom_range(0, 2));
                    1: h_reg = $urandom_range(0, 1) ? 11'd1024 : 11'h7FF;
                    default: h_reg = 11'($urandom_range(3, 10));
                endcase
                write_reg(rgbc_pkg::CFG_IMAGE_WIDTH, w_reg);
                write_reg(rgbc_pkg::CFG_IMAGE_HEIGHT, h_reg);
                settings_used++;
                // Without a frame start the new size takes over wherever the old
                // frame left the counters.
                queue_frames(SUB_ITEMS, clamp_size(w_reg, MAX_W),
                             clamp_size(h_reg, int'(rgbc_pkg::IMAGE_HEIGHT_MAX)),
                             $urandom_range(0, 1) == 1);
                if (mode == 0 && sub == 0) hold_trigger++;
                settle();
            end
        end

        leftover = filtered_q.size();
        if (leftover != 0) $error("%0d filtered pixels never arrived", leftover);
        $display("Checked %0d filtered pixels from %0d pixel beats over %0d size settings,",
                 results_checked, pixels_taken, settings_used);
        $display("with a full-width row, clamped sizes, frame restarts and a long output hold.");
        if (mismatches == 0 && leftover == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
design/rgbc_pkg.sv
design/rgbc_line_buf.sv
design/rgbc_window.sv
design/rgb_convolution_3x3.sv
tb/tb_rgb_convolution_3x3.sv
